FILE: rtl/wns_pkg.sv
`default_nettype none
package wns_pkg;

  localparam int LANES        = 4;
  localparam int PROJ_ENTRIES = 16;
  localparam int Q_W          = 24;
  localparam int P_W          = 18;
  localparam int GAIN_W       = 24;
  localparam int MT_W         = 23;
  localparam int AW_W         = 3;
  localparam int CFG_W        = 24;
  localparam int IDX_W        = 5;
  localparam int PROD_W       = P_W + Q_W;
  localparam int ACC_W        = PROD_W + 2;
  localparam int RND_W        = ACC_W - 16;
  localparam int SQ_W         = 2 * Q_W;
  localparam int SUMSQ_W      = SQ_W + 2;
  localparam int ROOT_W       = SUMSQ_W / 2;
  localparam int T_W          = 34;
  localparam int MAG_W        = T_W - 1;
  localparam int ML_W         = 17;
  localparam int MH_W         = MAG_W - ML_W;
  localparam int NUM_W        = MAG_W + MT_W;
  localparam int DIV_STEPS    = MT_W;
  localparam int SCALE_LAT    = DIV_STEPS + 2;
  localparam int LANE_LAT     = 3;
  localparam int PIPE_LAT     = LANE_LAT + 1 + SCALE_LAT;

  typedef logic signed [Q_W-1:0] q7_t;
  typedef logic signed [P_W-1:0] proj_t;

  typedef enum logic [1:0] {
    REG_GAIN,
    REG_MAX_TORQUE,
    REG_ACTIVE_WHEELS,
    REG_ENABLE
  } wns_reg_e;

  typedef enum logic {
    MODE_RUN  = 1'b0,
    MODE_LOAD = 1'b1
  } wns_mode_e;

  typedef struct packed {
    wns_mode_e        mode;
    logic [IDX_W-1:0] load_index;
    q7_t              load_value;
    q7_t              momentum_0;
    q7_t              momentum_1;
    q7_t              momentum_2;
    q7_t              momentum_3;
  } wns_in_t;

  typedef struct packed {
    q7_t            torque_0;
    q7_t            torque_1;
    q7_t            torque_2;
    q7_t            torque_3;
    logic [Q_W-1:0] null_norm;
    logic           valid_res;
    logic           steering;
    logic           refusal;
  } wns_out_t;

  typedef struct packed {
    wns_reg_e         reg_index;
    logic [CFG_W-1:0] reg_data;
  } wns_cfg_t;

  localparam q7_t P_MAX_Q = 24'sd131071;
  localparam q7_t P_MIN_Q = -24'sd131072;
  localparam logic signed [T_W-1:0] Q7_MAX_T = 34'sd8388607;
  localparam logic signed [T_W-1:0] Q7_MIN_T = -34'sd8388608;

  function automatic proj_t sat_proj(input q7_t v);
    proj_t r;
    if (v > P_MAX_Q) begin
      r = P_MAX_Q[P_W-1:0];
    end else if (v < P_MIN_Q) begin
      r = P_MIN_Q[P_W-1:0];
    end else begin
      r = v[P_W-1:0];
    end
    return r;
  endfunction

  function automatic q7_t sat_q7(input logic signed [T_W-1:0] v);
    q7_t r;
    if (v > Q7_MAX_T) begin
      r = Q7_MAX_T[Q_W-1:0];
    end else if (v < Q7_MIN_T) begin
      r = Q7_MIN_T[Q_W-1:0];
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/wns_chan_if.sv
`default_nettype none
interface wns_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/wns_lane.sv
`default_nettype none
// One wheel lane: projection row dot product, rounding, square and servo torque.
module wns_lane import wns_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic                    act_i,
  input  proj_t                   row_i [LANES],
  input  q7_t                     h_i [LANES],
  input  q7_t                     bias_i,
  input  logic [GAIN_W-1:0]       gain_i,
  output logic [SQ_W-1:0]         sq_o,
  output logic signed [T_W-1:0]   t_o,
  output logic                    bias_nz_o
);

  logic signed [PROD_W-1:0]  prod_q [LANES];
  logic                      act1_q, act2_q;
  q7_t                       bias1_q, bias2_q, hn_q, hn_d;
  logic signed [ACC_W-1:0]   acc;
  logic signed [RND_W-1:0]   rnd;
  logic signed [Q_W:0]       diff;
  logic signed [2*Q_W+1:0]   tprod;
  logic signed [SQ_W-1:0]    sq_s;

  always_comb begin
    acc = '0;
    for (int j = 0; j < LANES; j++) begin
      acc = acc + ACC_W'(prod_q[j]);
    end
    acc   = acc + ACC_W'(32768);
    rnd   = acc[ACC_W-1:16];
    hn_d  = sat_q7(T_W'(rnd));
    diff  = (Q_W+1)'(bias2_q) - (Q_W+1)'(hn_q);
    tprod = $signed({1'b0, gain_i}) * diff;
    tprod = tprod + (2*Q_W+2)'(32768);
    sq_s  = hn_q * hn_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < LANES; j++) begin
        prod_q[j] <= row_i[j] * h_i[j];
      end
      act1_q    <= act_i;
      bias1_q   <= bias_i;
      hn_q      <= act1_q ? hn_d : '0;
      bias2_q   <= bias1_q;
      act2_q    <= act1_q;
      sq_o      <= sq_s;
      t_o       <= act2_q ? tprod[2*Q_W+1:16] : '0;
      bias_nz_o <= act2_q && (bias2_q != '0);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/wns_sqrt.sv
`default_nettype none
// Pipelined integer square root, one result bit per stage.
module wns_sqrt import wns_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [SUMSQ_W-1:0] x_i,
  output logic [ROOT_W-1:0]  root_o
);

  localparam int REM_W = ROOT_W + 3;

  logic [SUMSQ_W-1:0] x_q    [ROOT_W-1];
  logic [REM_W-1:0]   rem_q  [ROOT_W];
  logic [ROOT_W-1:0]  root_q [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_step
    logic [SUMSQ_W-1:0] x_in;
    logic [REM_W-1:0]   rem_in, rem_sh, trial;
    logic [ROOT_W-1:0]  root_in;

    if (s == 0) begin : g_first
      assign x_in    = x_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign x_in    = x_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], x_in[SUMSQ_W-1 -: 2]};
    assign trial  = REM_W'({root_in, 2'b01});

    if (s < ROOT_W - 1) begin : g_shift
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[s] <= {x_in[SUMSQ_W-3:0], 2'b00};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_sh >= trial) begin
          rem_q[s]  <= rem_sh - trial;
          root_q[s] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[s]  <= rem_sh;
          root_q[s] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule
`default_nettype wire

FILE: rtl/wns_scale.sv
`default_nettype none
// Peak limiter for one lane: floor(mag * max / peak) by a pipelined restoring divider when peak > max, else mag.
module wns_scale import wns_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [MAG_W-1:0] mag_i,
  input  logic [MAG_W-1:0] peak_i,
  input  logic [MT_W-1:0]  mt_i,
  output logic [MAG_W-1:0] mag_o
);

  logic [MH_W+MT_W-1:0] ph_q;
  logic [ML_W+MT_W-1:0] pl_q;
  logic [MAG_W-1:0]     mag1_q, peak1_q, mag2_q, peak2_q;
  logic                 scl1_q, scl2_q;
  logic [NUM_W-1:0]     num_q;

  logic [MAG_W-1:0]     rem_q  [DIV_STEPS];
  logic [MT_W-1:0]      quo_q  [DIV_STEPS];
  logic [DIV_STEPS-1:0] lo_q   [DIV_STEPS];
  logic [MAG_W-1:0]     mag_q  [DIV_STEPS];
  logic [MAG_W-1:0]     peak_q [DIV_STEPS];
  logic                 scl_q  [DIV_STEPS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q    <= mag_i[MAG_W-1:ML_W] * mt_i;
      pl_q    <= mag_i[ML_W-1:0] * mt_i;
      mag1_q  <= mag_i;
      peak1_q <= peak_i;
      scl1_q  <= peak_i > MAG_W'(mt_i);
      num_q   <= (NUM_W'(ph_q) << ML_W) + NUM_W'(pl_q);
      mag2_q  <= mag1_q;
      peak2_q <= peak1_q;
      scl2_q  <= scl1_q;
    end
  end

  for (genvar d = 0; d < DIV_STEPS; d++) begin : g_div
    logic [MAG_W-1:0]     rem_in, mag_in, peak_in;
    logic [MT_W-1:0]      quo_in;
    logic [DIV_STEPS-1:0] lo_in;
    logic                 scl_in;
    logic [MAG_W:0]       r_sh;

    if (d == 0) begin : g_first
      assign rem_in  = num_q[NUM_W-1:DIV_STEPS];
      assign quo_in  = '0;
      assign lo_in   = num_q[DIV_STEPS-1:0];
      assign mag_in  = mag2_q;
      assign peak_in = peak2_q;
      assign scl_in  = scl2_q;
    end else begin : g_next
      assign rem_in  = rem_q[d-1];
      assign quo_in  = quo_q[d-1];
      assign lo_in   = lo_q[d-1];
      assign mag_in  = mag_q[d-1];
      assign peak_in = peak_q[d-1];
      assign scl_in  = scl_q[d-1];
    end

    assign r_sh = {rem_in, lo_in[DIV_STEPS-1-d]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (r_sh >= {1'b0, peak_in}) begin
          rem_q[d] <= MAG_W'(r_sh - {1'b0, peak_in});
          quo_q[d] <= {quo_in[MT_W-2:0], 1'b1};
        end else begin
          rem_q[d] <= r_sh[MAG_W-1:0];
          quo_q[d] <= {quo_in[MT_W-2:0], 1'b0};
        end
        lo_q[d]   <= lo_in;
        mag_q[d]  <= mag_in;
        peak_q[d] <= peak_in;
        scl_q[d]  <= scl_in;
      end
    end
  end

  assign mag_o = scl_q[DIV_STEPS-1] ? MAG_W'(quo_q[DIV_STEPS-1]) : mag_q[DIV_STEPS-1];

endmodule
`default_nettype wire

FILE: rtl/wheel_null_space_bias_servo.sv
// Throughput: one item per cycle while the output buffer has room; the 25-step
// square root and the 23-step per-lane divider are fully pipelined and set the depth.
// Reset: configuration returns to gain 0, max torque 0, four wheels, disabled;
// the pipeline and the two-entry output buffer empty. Tables stay unwritten.
`default_nettype none
module wheel_null_space_bias_servo import wns_pkg::*; #(
  parameter int WHEELS = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  wns_chan_if.sink        in_i,
  wns_chan_if.source      out_o,
  wns_chan_if.sink        cfg_i
);

  localparam logic [1:0] SKID_DEPTH = 2'd2;

  // Configuration registers. Writes must arrive only while the block is idle (the
  // block itself does not enforce this), so every stage may read them directly.
  logic [GAIN_W-1:0] gain_q;
  logic [MT_W-1:0]   mt_q;
  logic [AW_W-1:0]   aw_q;
  logic              enable_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= '0;
      mt_q     <= '0;
      aw_q     <= AW_W'(4);
      enable_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.reg_index)
        REG_GAIN:          gain_q   <= cfg_i.data.reg_data[GAIN_W-1:0];
        REG_MAX_TORQUE:    mt_q     <= cfg_i.data.reg_data[MT_W-1:0];
        REG_ACTIVE_WHEELS: aw_q     <= cfg_i.data.reg_data[AW_W-1:0];
        REG_ENABLE:        enable_q <= cfg_i.data.reg_data[0];
        default:           enable_q <= enable_q;
      endcase
    end
  end

  // The whole pipeline moves whenever the output buffer has room, so the
  // input keeps taking items while one finished result waits downstream.
  logic [1:0] cnt_q;
  logic       advance, accept, run_acc, load_acc;

  assign advance    = (cnt_q != SKID_DEPTH);
  assign in_i.ready = advance;
  assign accept     = in_i.valid && advance;
  assign run_acc    = accept && (in_i.data.mode == MODE_RUN);
  assign load_acc   = accept && (in_i.data.mode == MODE_LOAD);

  // Table writes happen at the transfer itself. Each lane snapshots its row
  // and bias in its first stage, so a later load never disturbs a run item
  // that is still in flight.
  proj_t proj_q [PROJ_ENTRIES];
  q7_t   bias_q [LANES];

  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      if (!in_i.data.load_index[IDX_W-1]) begin
        proj_q[in_i.data.load_index[3:0]] <= sat_proj(in_i.data.load_value);
      end else if (in_i.data.load_index[3:2] == 2'b00) begin
        bias_q[in_i.data.load_index[1:0]] <= in_i.data.load_value;
      end
    end
  end

  // Unconfigured check and lane masking.
  logic refused;
  logic act [LANES];
  q7_t  mom [LANES];
  q7_t  h   [LANES];

  assign refused = !enable_q || (aw_q < AW_W'(3)) || (int'(aw_q) > LANES) ||
                   (int'(aw_q) > WHEELS) || ((gain_q != '0) && (mt_q == '0));

  assign mom[0] = in_i.data.momentum_0;
  assign mom[1] = in_i.data.momentum_1;
  assign mom[2] = in_i.data.momentum_2;
  assign mom[3] = in_i.data.momentum_3;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      act[i] = int'(aw_q) > i;
      h[i]   = act[i] ? mom[i] : '0;
    end
  end

  // Lanes: projection, norm squares and unscaled torques.
  logic [SQ_W-1:0]       sq    [LANES];
  logic signed [T_W-1:0] t     [LANES];
  logic                  bnz   [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    proj_t row [LANES];
    for (genvar j = 0; j < LANES; j++) begin : g_row
      assign row[j] = proj_q[i*LANES + j];
    end
    wns_lane u_lane (
      .clk_i     (clk_i),
      .en_i      (advance),
      .act_i     (act[i]),
      .row_i     (row),
      .h_i       (h),
      .bias_i    (bias_q[i]),
      .gain_i    (gain_q),
      .sq_o      (sq[i]),
      .t_o       (t[i]),
      .bias_nz_o (bnz[i])
    );
  end

  // Merge stage: sum of squares, magnitudes, peak and the steering-off flag.
  logic [SUMSQ_W-1:0] sumsq_d, sumsq_q;
  logic [MAG_W-1:0]   mag_d  [LANES];
  logic [MAG_W-1:0]   mag_q  [LANES];
  logic [MAG_W-1:0]   peak_d, peak_q;
  logic [LANES-1:0]   neg_d;
  logic               off_d;

  always_comb begin
    sumsq_d = '0;
    peak_d  = '0;
    off_d   = (gain_q == '0);
    for (int i = 0; i < LANES; i++) begin
      sumsq_d  = sumsq_d + SUMSQ_W'(sq[i]);
      neg_d[i] = t[i][T_W-1];
      mag_d[i] = neg_d[i] ? MAG_W'(-t[i]) : MAG_W'(t[i]);
      if (mag_d[i] > peak_d) begin
        peak_d = mag_d[i];
      end
    end
    if (!(bnz[0] || bnz[1] || bnz[2] || bnz[3])) begin
      off_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sumsq_q <= sumsq_d;
      peak_q  <= peak_d;
      for (int i = 0; i < LANES; i++) begin
        mag_q[i] <= mag_d[i];
      end
    end
  end

  // Long stages: square root of the norm and per-lane peak scaling.
  logic [ROOT_W-1:0] root;
  logic [MAG_W-1:0]  mag_fin [LANES];

  wns_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (advance),
    .x_i    (sumsq_q),
    .root_o (root)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_scale
    wns_scale u_scale (
      .clk_i  (clk_i),
      .en_i   (advance),
      .mag_i  (mag_q[i]),
      .peak_i (peak_q),
      .mt_i   (mt_q),
      .mag_o  (mag_fin[i])
    );
  end

  // Side-band pipeline: item valid and refusal from the transfer on, signs and
  // steering-off from the merge stage on.
  logic             vld_q [PIPE_LAT];
  logic             ref_q [PIPE_LAT];
  logic [LANES-1:0] neg_q [SCALE_LAT+1];
  logic             off_q [SCALE_LAT+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PIPE_LAT; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (advance) begin
      vld_q[0] <= run_acc;
      for (int k = 1; k < PIPE_LAT; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ref_q[0] <= refused;
      for (int k = 1; k < PIPE_LAT; k++) begin
        ref_q[k] <= ref_q[k-1];
      end
      neg_q[0] <= neg_d;
      off_q[0] <= off_d;
      for (int k = 1; k <= SCALE_LAT; k++) begin
        neg_q[k] <= neg_q[k-1];
        off_q[k] <= off_q[k-1];
      end
    end
  end

  // Final assembly of the result item.
  wns_out_t res_d;
  q7_t      tq [LANES];
  logic     zero_t, steer;

  always_comb begin
    zero_t = ref_q[PIPE_LAT-1] || off_q[SCALE_LAT];
    steer  = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      tq[i] = neg_q[SCALE_LAT][i] ? sat_q7(-T_W'(mag_fin[i])) : sat_q7(T_W'(mag_fin[i]));
      if (zero_t) begin
        tq[i] = '0;
      end
      if (tq[i] != '0) begin
        steer = 1'b1;
      end
    end
    res_d.torque_0  = tq[0];
    res_d.torque_1  = tq[1];
    res_d.torque_2  = tq[2];
    res_d.torque_3  = tq[3];
    res_d.null_norm = root[ROOT_W-1] ? '1 : root[Q_W-1:0];
    if (ref_q[PIPE_LAT-1]) begin
      res_d.null_norm = '0;
    end
    res_d.valid_res = !ref_q[PIPE_LAT-1];
    res_d.steering  = steer;
    res_d.refusal   = ref_q[PIPE_LAT-1];
  end

  // Two-entry output buffer; the head entry drives the result channel.
  wns_out_t e_q [2];
  logic     push, pop;

  assign push         = advance && vld_q[PIPE_LAT-1];
  assign pop          = out_o.valid && out_o.ready;
  assign out_o.valid  = (cnt_q != 2'd0);
  assign out_o.data   = e_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && ((cnt_q == 2'd0) || (pop && (cnt_q == 2'd1)))) begin
      e_q[0] <= res_d;
    end else if (pop) begin
      e_q[0] <= e_q[1];
    end
    if (push && !pop && (cnt_q == 2'd1)) begin
      e_q[1] <= res_d;
    end
  end

  // Checks on the assembled results.
  logic in_bound;
  q7_t  mt_s;

  assign mt_s     = $signed({1'b0, mt_q});
  assign in_bound = (out_o.data.torque_0 <= mt_s) && (out_o.data.torque_0 >= -mt_s) &&
                    (out_o.data.torque_1 <= mt_s) && (out_o.data.torque_1 >= -mt_s) &&
                    (out_o.data.torque_2 <= mt_s) && (out_o.data.torque_2 >= -mt_s) &&
                    (out_o.data.torque_3 <= mt_s) && (out_o.data.torque_3 >= -mt_s);

  a_refusal_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.refusal) |->
      (!out_o.data.valid_res && !out_o.data.steering && (out_o.data.null_norm == '0)))
    else $error("refused result carries data");

  a_steering_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.data.steering == ((out_o.data.torque_0 != '0) ||
      (out_o.data.torque_1 != '0) || (out_o.data.torque_2 != '0) ||
      (out_o.data.torque_3 != '0))))
    else $error("steering flag disagrees with torques");

  a_torque_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.valid_res) |-> in_bound)
    else $error("torque exceeds max_torque");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == SKID_DEPTH) |=> (cnt_q != 2'd3))
    else $error("output buffer overflow");

endmodule
`default_nettype wire
